FILE: src/sll_pkg.sv
`default_nettype none

package sll_pkg;

    localparam int NODES  = 64;
    localparam int LINK_W = $clog2(NODES);
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [LINK_W-1:0] HEAD_NODE = LINK_W'(NODES - 1);
    localparam logic [LINK_W-1:0] FREE_NODE = '0;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_ERR   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Read address sources.
    localparam logic [2:0] RA_CUR  = 3'd0;
    localparam logic [2:0] RA_LINK = 3'd1;
    localparam logic [2:0] RA_FREE = 3'd2;
    localparam logic [2:0] RA_HEAD = 3'd3;

    // Write address sources.
    localparam logic [1:0] WA_FREE = 2'd0;
    localparam logic [1:0] WA_NODE = 2'd1;
    localparam logic [1:0] WA_CUR  = 2'd2;

    // Write data sources.
    localparam logic WD_LINK = 1'b0;
    localparam logic WD_NODE = 1'b1;

    typedef struct packed {
        logic              in_load;
        logic              rd_en;
        logic [2:0]        rd_sel;
        logic              wr_en;
        logic [1:0]        wr_sel;
        logic              wd_sel;
        logic              val_wr;
        logic              cur_head;
        logic              cur_link;
        logic              cnt_dec;
        logic              node_load;
        logic              out_load;
        logic [STAT_W-1:0] out_status;
        logic              out_dump;
    } sll_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              pos_zero;
        logic              cnt_zero;
        logic              cnt_one;
        logic              link_zero;
        logic              out_fire;
        logic              out_last;
    } sll_stat_t;

    // Link of a node that was never written: the free chain as it stands after reset.
    function automatic logic [LINK_W-1:0] reset_link(input logic [LINK_W-1:0] node);
        logic [LINK_W-1:0] res;
        begin
            res = '0;
            if (int'(node) < NODES - 2)
            begin
                res = LINK_W'(node + 1'b1);
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/sll_datapath.sv
`default_nettype none

module sll_datapath
    import sll_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sll_cmd_t                cmd,
    output sll_stat_t                    stat,
    input  wire logic [KIND_W-1:0]       in_kind,
    input  wire logic [POS_W-1:0]        in_position,
    input  wire logic signed [VAL_W-1:0] in_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [STAT_W-1:0]            out_status,
    output logic signed [VAL_W-1:0]      out_element,
    output logic                         out_last
);

    logic [LINK_W-1:0]       link_mem [NODES];
    logic signed [VAL_W-1:0] val_mem  [NODES];
    logic [NODES-1:0]        written_reg;

    logic [KIND_W-1:0]       kind_reg;
    logic                    pos_zero_reg;
    logic [POS_W-1:0]        cnt_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [LINK_W-1:0]       cur_reg;
    logic [LINK_W-1:0]       node_reg;

    logic [LINK_W-1:0]       link_q_reg;
    logic signed [VAL_W-1:0] val_q_reg;
    logic [LINK_W-1:0]       rd_addr_reg;
    logic                    rd_written_reg;

    logic                    out_valid_reg;
    logic [STAT_W-1:0]       out_status_reg;
    logic signed [VAL_W-1:0] out_element_reg;
    logic                    out_last_reg;

    logic [LINK_W-1:0]       link_rd;
    logic [LINK_W-1:0]       rd_addr;
    logic [LINK_W-1:0]       wr_addr;
    logic [LINK_W-1:0]       wr_data;

    // Entries never written read as their reset link.
    assign link_rd = rd_written_reg ? link_q_reg : reset_link(rd_addr_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RA_CUR:  rd_addr = cur_reg;
            RA_LINK: rd_addr = link_rd;
            RA_FREE: rd_addr = FREE_NODE;
            RA_HEAD: rd_addr = HEAD_NODE;
            default: rd_addr = cur_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WA_FREE: wr_addr = FREE_NODE;
            WA_NODE: wr_addr = node_reg;
            WA_CUR:  wr_addr = cur_reg;
            default: wr_addr = cur_reg;
        endcase
    end

    assign wr_data = (cmd.wd_sel == WD_NODE) ? node_reg : link_rd;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            link_q_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.val_wr)
        begin
            val_mem[node_reg] <= value_reg;
        end
        if (cmd.rd_en)
        begin
            val_q_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_addr_reg    <= rd_addr;
            rd_written_reg <= written_reg[rd_addr];
        end
        if (cmd.in_load)
        begin
            kind_reg     <= in_kind;
            pos_zero_reg <= (in_position == '0);
            cnt_reg      <= POS_W'(in_position - 1'b1);
            value_reg    <= in_value;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_reg <= POS_W'(cnt_reg - 1'b1);
        end
        if (cmd.cur_head)
        begin
            cur_reg <= HEAD_NODE;
        end
        else if (cmd.cur_link)
        begin
            cur_reg <= link_rd;
        end
        if (cmd.node_load)
        begin
            node_reg <= link_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg  <= cmd.out_status;
            out_element_reg <= cmd.out_dump ? val_q_reg : '0;
            out_last_reg    <= cmd.out_dump ? (link_rd == '0) : 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_element = out_element_reg;
    assign out_last    = out_last_reg;

    assign stat.kind      = kind_reg;
    assign stat.pos_zero  = pos_zero_reg;
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.cnt_one   = (cnt_reg == POS_W'(1));
    assign stat.link_zero = (link_rd == '0);
    assign stat.out_fire  = out_valid_reg && out_ready;
    assign stat.out_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: src/sll_ctrl.sv
`default_nettype none

module sll_ctrl
    import sll_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire sll_stat_t stat,
    output sll_cmd_t       cmd
);

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_DECODE     = 5'd1;
    localparam logic [4:0] S_WALK       = 5'd2;
    localparam logic [4:0] S_POS_DONE   = 5'd3;
    localparam logic [4:0] S_INS_FREE   = 5'd4;
    localparam logic [4:0] S_INS_FNEXT  = 5'd5;
    localparam logic [4:0] S_INS_PNEXT  = 5'd6;
    localparam logic [4:0] S_INS_LINK   = 5'd7;
    localparam logic [4:0] S_DEL_VICTIM = 5'd8;
    localparam logic [4:0] S_DEL_VNEXT  = 5'd9;
    localparam logic [4:0] S_DEL_FREE   = 5'd10;
    localparam logic [4:0] S_DEL_PUSH   = 5'd11;
    localparam logic [4:0] S_OK         = 5'd12;
    localparam logic [4:0] S_ERR        = 5'd13;
    localparam logic [4:0] S_DUMP_FIRST = 5'd14;
    localparam logic [4:0] S_DUMP_LOAD  = 5'd15;
    localparam logic [4:0] S_OUT_WAIT   = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RA_CUR;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.cur_head = 1'b1;
                if (stat.kind == KIND_DUMP)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_HEAD;
                    state_next = S_DUMP_FIRST;
                end
                else if ((stat.kind != KIND_INSERT && stat.kind != KIND_DELETE)
                         || stat.pos_zero)
                begin
                    state_next = S_ERR;
                end
                else if (stat.cnt_zero)
                begin
                    state_next = S_POS_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_HEAD;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // One link per cycle: the data just read addresses the next read.
                if (stat.link_zero)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.cur_link = 1'b1;
                    cmd.cnt_dec  = 1'b1;
                    if (stat.cnt_one)
                    begin
                        state_next = S_POS_DONE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_LINK;
                    end
                end
            end
            S_POS_DONE:
            begin
                cmd.rd_en = 1'b1;
                if (stat.kind == KIND_INSERT)
                begin
                    cmd.rd_sel = RA_FREE;
                    state_next = S_INS_FREE;
                end
                else
                begin
                    cmd.rd_sel = RA_CUR;
                    state_next = S_DEL_VICTIM;
                end
            end
            S_INS_FREE:
            begin
                if (stat.link_zero)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.node_load = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RA_LINK;
                    state_next    = S_INS_FNEXT;
                end
            end
            S_INS_FNEXT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_FREE;
                cmd.wd_sel = WD_LINK;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_CUR;
                state_next = S_INS_PNEXT;
            end
            S_INS_PNEXT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_NODE;
                cmd.wd_sel = WD_LINK;
                cmd.val_wr = 1'b1;
                state_next = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_CUR;
                cmd.wd_sel = WD_NODE;
                state_next = S_OK;
            end
            S_DEL_VICTIM:
            begin
                if (stat.link_zero)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.node_load = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RA_LINK;
                    state_next    = S_DEL_VNEXT;
                end
            end
            S_DEL_VNEXT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_CUR;
                cmd.wd_sel = WD_LINK;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RA_FREE;
                state_next = S_DEL_FREE;
            end
            S_DEL_FREE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_NODE;
                cmd.wd_sel = WD_LINK;
                state_next = S_DEL_PUSH;
            end
            S_DEL_PUSH:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_FREE;
                cmd.wd_sel = WD_NODE;
                state_next = S_OK;
            end
            S_OK:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_OK;
                state_next     = S_OUT_WAIT;
            end
            S_ERR:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_ERR;
                state_next     = S_OUT_WAIT;
            end
            S_DUMP_FIRST:
            begin
                if (stat.link_zero)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_EMPTY;
                    state_next     = S_OUT_WAIT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_LINK;
                    state_next = S_DUMP_LOAD;
                end
            end
            S_DUMP_LOAD:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_OK;
                cmd.out_dump   = 1'b1;
                cmd.cur_link   = 1'b1;
                state_next     = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (stat.out_fire)
                begin
                    if (stat.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_CUR;
                        state_next = S_DUMP_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/static_linked_list_engine.sv
// An insert or delete at position p walks p - 1 links from the head, then gives one result;
// a dump gives its elements one by one, each read after the sink took the one before. One
// item is worked on at a time; the pointer walk reads one link per cycle from the
// single-read-port link memory. Reset (rst_n low, asynchronous) empties the list and
// rebuilds the free chain at once through per-node bits.
`default_nettype none

module static_linked_list_engine
    import sll_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [5:0] position, [37:6] value, [39:38] zero
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] element
    output logic [1:0]       m_axis_tuser,  // [1:0] status
    output logic             m_axis_tlast
);

    sll_cmd_t                cmd;
    sll_stat_t               stat;
    logic signed [VAL_W-1:0] element;

    sll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sll_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_axis_tuser),
        .in_position (s_axis_tdata[POS_W-1:0]),
        .in_value    (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (m_axis_tuser),
        .out_element (element),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = element;

endmodule

`default_nettype wire

FILE: dv/sll_checker.sv
`timescale 1ns / 1ps

module sll_reply_checker
    import sll_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_ready,
    input  wire logic [39:0] req_data,   // [5:0] position, [37:6] value, [39:38] zero
    input  wire logic [1:0]  req_user,   // [1:0] kind
    input  wire logic        rsp_valid,
    input  wire logic        rsp_ready,
    input  wire logic [31:0] rsp_data,   // [31:0] element
    input  wire logic [1:0]  rsp_user,   // [1:0] status
    input  wire logic        rsp_last,
    output int               mismatches,
    output int               replies_due
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  element;
        logic              last;
    } reply_t;

    reply_t            reply_q [$];
    reply_t            head_reply;
    logic [LINK_W-1:0] link_mem  [NODES];
    logic [VAL_W-1:0]  value_mem [NODES];

    // Follows steps links from the list head; fails if the chain ends first.
    function automatic bit walk_list(input int steps, output logic [LINK_W-1:0] at);
        logic [LINK_W-1:0] n;
        n = HEAD_NODE;
        for (int s = 0; s < steps; s++)
        begin
            n = link_mem[n];
            if (n == FREE_NODE)
            begin
                return 1'b0;
            end
        end
        at = n;
        return 1'b1;
    endfunction

    task automatic push_reply(input logic [STAT_W-1:0] status, input logic [VAL_W-1:0] element,
                              input logic last);
        reply_t r;
        r.status  = status;
        r.element = element;
        r.last    = last;
        reply_q.push_back(r);
    endtask

    task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] val);
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] fresh;
        logic [LINK_W-1:0] victim;
        logic [LINK_W-1:0] n;
        int                count;
        reply_t            tail;
        case (kind)
            KIND_INSERT:
            begin
                // The position is checked before a free node is taken.
                if (pos == '0 || !walk_list(int'(pos) - 1, prev))
                begin
                    push_reply(ST_ERR, '0, 1'b1);
                end
                else
                begin
                    fresh = link_mem[FREE_NODE];
                    if (fresh == FREE_NODE)
                    begin
                        push_reply(ST_ERR, '0, 1'b1);
                    end
                    else
                    begin
                        link_mem[FREE_NODE] = link_mem[fresh];
                        value_mem[fresh]    = val;
                        link_mem[fresh]     = link_mem[prev];
                        link_mem[prev]      = fresh;
                        push_reply(ST_OK, '0, 1'b1);
                    end
                end
            end
            KIND_DELETE:
            begin
                if (pos == '0 || !walk_list(int'(pos) - 1, prev))
                begin
                    push_reply(ST_ERR, '0, 1'b1);
                end
                else
                begin
                    victim = link_mem[prev];
                    if (victim == FREE_NODE)
                    begin
                        push_reply(ST_ERR, '0, 1'b1);
                    end
                    else
                    begin
                        link_mem[prev]      = link_mem[victim];
                        link_mem[victim]    = link_mem[FREE_NODE];
                        link_mem[FREE_NODE] = victim;
                        push_reply(ST_OK, '0, 1'b1);
                    end
                end
            end
            KIND_DUMP:
            begin
                n = link_mem[HEAD_NODE];
                if (n == FREE_NODE)
                begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    count = 0;
                    while (n != FREE_NODE && count < NODES - 2)
                    begin
                        push_reply(ST_OK, value_mem[n], 1'b0);
                        count++;
                        n = link_mem[n];
                    end
                    tail      = reply_q.pop_back();
                    tail.last = 1'b1;
                    reply_q.push_back(tail);
                end
            end
            default:
            begin
                push_reply(ST_ERR, '0, 1'b1);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                link_mem[i] = (i < NODES - 2) ? LINK_W'(i + 1) : FREE_NODE;
            end
            reply_q.delete();
            mismatches  <= 0;
            replies_due <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected item: status %0d element %h last %0d",
                                 $realtime, rsp_user, rsp_data, rsp_last);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    head_reply = reply_q.pop_front();
                    if (rsp_user !== head_reply.status || rsp_data !== head_reply.element ||
                        rsp_last !== head_reply.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch: expected status %0d element %h last %0d, %s",
                                     $realtime, head_reply.status, head_reply.element,
                                     head_reply.last, "got");
                            $display("    status %0d element %h last %0d",
                                     rsp_user, rsp_data, rsp_last);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                apply_request(req_user, req_data[5:0], req_data[37:6]);
            end
            replies_due <= reply_q.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import sll_pkg::*;
();

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_ELEMS      = NODES - 2;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // [5:0] position, [37:6] value, [39:38] zero
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] element
    logic [1:0]  m_axis_tuser;         // [1:0] status
    logic        m_axis_tlast;

    int mismatches;
    int replies_due;
    int idle_cycles = 0;
    int list_len    = 0;
    int send_calm   = 0;

    always #10 clk = ~clk;

    static_linked_list_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sll_reply_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_data    (s_axis_tdata),
        .req_user    (s_axis_tuser),
        .rsp_valid   (m_axis_tvalid),
        .rsp_ready   (m_axis_tready),
        .rsp_data    (m_axis_tdata),
        .rsp_user    (m_axis_tuser),
        .rsp_last    (m_axis_tlast),
        .mismatches  (mismatches),
        .replies_due (replies_due)
    );

    // Offers one request after a random gap and tracks the list length for stimulus shaping.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        int gap;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 19);
            if ($urandom_range(0, 29) == 0)
            begin
                send_calm = $urandom_range(10, 40);
            end
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, val, pos};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (kind == KIND_INSERT && pos >= 1 && int'(pos) <= list_len + 1 &&
            list_len < MAX_ELEMS)
        begin
            list_len++;
        end
        else if (kind == KIND_DELETE && pos >= 1 && int'(pos) <= list_len)
        begin
            list_len--;
        end
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Weights select insert, delete, dump, out-of-range position and the unused kind.
    task automatic random_request(input int w_ins, input int w_del, input int w_dump,
                                  input int w_bad, input int w_odd);
        int r;
        int p;
        r = $urandom_range(0, w_ins + w_del + w_dump + w_bad + w_odd - 1);
        if (r < w_ins)
        begin
            case ($urandom_range(0, 3))
                0:       p = 1;
                1:       p = list_len + 1;
                default: p = $urandom_range(1, list_len + 1);
            endcase
            send_request(KIND_INSERT, POS_W'(p), pick_value());
        end
        else if (r < w_ins + w_del)
        begin
            if (list_len > 0)
            begin
                case ($urandom_range(0, 3))
                    0:       p = 1;
                    1:       p = list_len;
                    default: p = $urandom_range(1, list_len);
                endcase
            end
            else
            begin
                p = $urandom_range(0, 63);
            end
            send_request(KIND_DELETE, POS_W'(p), pick_value());
        end
        else if (r < w_ins + w_del + w_dump)
        begin
            send_request(KIND_DUMP, POS_W'($urandom_range(0, 63)), pick_value());
        end
        else if (r < w_ins + w_del + w_dump + w_bad)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                p = (list_len + 2 <= 63 && $urandom_range(0, 2) != 0) ?
                    $urandom_range(list_len + 2, 63) : 0;
                send_request(KIND_INSERT, POS_W'(p), pick_value());
            end
            else
            begin
                p = ($urandom_range(0, 2) != 0) ? $urandom_range(list_len + 1, 63) : 0;
                send_request(KIND_DELETE, POS_W'(p), pick_value());
            end
        end
        else
        begin
            send_request(KIND_UNUSED, POS_W'($urandom_range(0, 63)), pick_value());
        end
    endtask

    // Sink side: a random stall before each item, with stretches of no stall.
    initial
    begin
        int stall;
        int calm;
        calm = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (calm > 0)
            begin
                calm--;
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 19);
                if ($urandom_range(0, 24) == 0)
                begin
                    calm = $urandom_range(20, 60);
                end
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, bad positions, inserts at front, middle and tail, deletes, dumps, the unused kind.
        send_request(KIND_DUMP,   6'd0,  32'h0000_0000);
        send_request(KIND_DELETE, 6'd1,  32'h1234_5678);
        send_request(KIND_INSERT, 6'd0,  32'hdead_beef);
        send_request(KIND_INSERT, 6'd2,  32'hdead_beef);
        send_request(KIND_INSERT, 6'd1,  32'h7fff_ffff);
        send_request(KIND_INSERT, 6'd1,  32'h8000_0000);
        send_request(KIND_INSERT, 6'd3,  32'h0000_0000);
        send_request(KIND_INSERT, 6'd2,  32'hffff_ffff);
        send_request(KIND_INSERT, 6'd63, 32'h0bad_f00d);
        send_request(KIND_DUMP,   6'd63, 32'hffff_ffff);
        send_request(KIND_UNUSED, 6'd1,  32'h1357_9bdf);
        send_request(KIND_DELETE, 6'd0,  32'h0000_0000);
        send_request(KIND_DELETE, 6'd5,  32'h0000_0000);
        send_request(KIND_DELETE, 6'd4,  32'h0000_0000);
        send_request(KIND_DELETE, 6'd1,  32'h0000_0000);
        send_request(KIND_DUMP,   6'd1,  32'h0000_0000);
        send_request(KIND_DELETE, 6'd63, 32'hffff_ffff);
        send_request(KIND_INSERT, 6'd2,  32'h5555_5555);
        send_request(KIND_INSERT, 6'd1,  32'haaaa_aaaa);
        send_request(KIND_DUMP,   6'd42, 32'h2468_ace0);
        send_request(KIND_UNUSED, 6'd63, 32'hffff_ffff);

        // Fill the store until inserts run into the full case.
        repeat (90) random_request(85, 5, 5, 3, 2);

        // Hold off until the block has delivered everything owed so far.
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0) @(posedge clk);

        // Drain to empty, then a long mixed stretch.
        repeat (90) random_request(5, 80, 8, 5, 2);
        repeat (180) random_request(35, 30, 15, 15, 5);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && replies_due == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
